@@ rtl/pmq_pkg.sv @@
// shared types and constants of the priority message queue
package pmq_pkg;

  // built depth and stored payload width
  localparam int DEPTH    = 16;
  localparam int MSG_BITS = 32;

  // field and counter widths
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int IDX_W    = $clog2(DEPTH);
  localparam int PRIO_W   = 8;
  localparam int DATA_W   = 32;
  localparam int HELD_W   = 5;
  localparam int CAP_W    = 5;
  localparam int LIM_W    = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int CAP_RST  = 16;

  // command codes
  typedef enum logic [1:0] {
    CMD_PUT = 2'd0,
    CMD_GET = 2'd1,
    CMD_CLR = 2'd2,
    CMD_NOP = 2'd3
  } cmd_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // register index on the configuration port
  localparam logic REG_CAPACITY = 1'b0;

  // control broadcast to every cell
  typedef struct packed {
    logic                put;
    logic                get;
    logic [PRIO_W-1:0]   prio;
    logic [MSG_BITS-1:0] data;
  } cell_ctl_t;

endpackage

@@ rtl/pmq_cell.sv @@
// one slot of the sorted shift-register queue
module pmq_cell (
  input  logic                           clk_i,
  input  pmq_pkg::cell_ctl_t             ctl_i,
  input  logic [pmq_pkg::IDX_W-1:0]      idx_i,
  input  logic [pmq_pkg::CNT_W-1:0]      count_i,
  input  logic                           left_ins_i,
  input  logic [pmq_pkg::MSG_BITS-1:0]   left_data_i,
  input  logic [pmq_pkg::PRIO_W-1:0]     left_prio_i,
  input  logic [pmq_pkg::MSG_BITS-1:0]   right_data_i,
  input  logic [pmq_pkg::PRIO_W-1:0]     right_prio_i,
  output logic                           ins_o,
  output logic [pmq_pkg::MSG_BITS-1:0]   data_o,
  output logic [pmq_pkg::PRIO_W-1:0]     prio_o
);
  import pmq_pkg::*;

  logic [MSG_BITS-1:0] data_q, data_d;
  logic [PRIO_W-1:0]   prio_q, prio_d;
  logic                occupied;

  // a new item belongs here or further left when this slot is free or lower
  assign occupied = CNT_W'(idx_i) < count_i;
  assign ins_o    = !occupied || (ctl_i.prio > prio_q);

  // put shifts right from the insert point, get shifts everything left
  always_comb begin
    data_d = data_q;
    prio_d = prio_q;
    if (ctl_i.put) begin
      if (left_ins_i) begin
        data_d = left_data_i;
        prio_d = left_prio_i;
      end else if (ins_o) begin
        data_d = ctl_i.data;
        prio_d = ctl_i.prio;
      end
    end else if (ctl_i.get) begin
      data_d = right_data_i;
      prio_d = right_prio_i;
    end
  end

  // slot storage
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    prio_q <= prio_d;
  end

  assign data_o = data_q;
  assign prio_o = prio_q;

endmodule

@@ rtl/priority_message_queue.sv @@
// priority message queue: command port, capacity register and the row of slot cells
// the result strobe is registered and follows in the cycle after the item is accepted
// throughput: one item per cycle, every slot cell compares and shifts in parallel
// busy stays low; the receiver cannot stall and takes each result in its cycle
// reset: the queue is empty and capacity is 16; slot contents are not cleared
module priority_message_queue (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    cmd_i,
  input  logic [pmq_pkg::DATA_W-1:0]    put_data_i,
  input  logic [pmq_pkg::PRIO_W-1:0]    put_priority_i,
  output logic                          done_o,
  output logic [1:0]                    status_o,
  output logic [pmq_pkg::DATA_W-1:0]    got_data_o,
  output logic [pmq_pkg::PRIO_W-1:0]    got_priority_o,
  output logic [pmq_pkg::HELD_W-1:0]    held_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import pmq_pkg::*;

  logic [CAP_W-1:0]    cap_q;
  logic [CNT_W-1:0]    count_q, count_d;
  logic                done_q;
  logic [1:0]          status_q, status_d;
  logic [DATA_W-1:0]   got_data_q, got_data_d;
  logic [PRIO_W-1:0]   got_prio_q, got_prio_d;
  logic                accept;
  cmd_e                cmd;
  logic [LIM_W-1:0]    limit;
  logic                full;
  logic                empty;
  logic [63:0]         put_wide;
  logic [63:0]         head_wide;
  cell_ctl_t           ctl;

  logic                ins    [DEPTH];
  logic [MSG_BITS-1:0] c_data [DEPTH];
  logic [PRIO_W-1:0]   c_prio [DEPTH];

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_CAPACITY) ? 32'(cap_q) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_W'(CAP_RST);
    end else if (psel && penable && pwrite && (paddr[2] == REG_CAPACITY)) begin
      cap_q <= pwdata[CAP_W-1:0];
    end
  end

  // effective capacity, clamped to 1..DEPTH
  always_comb begin
    limit = LIM_W'(cap_q);
    if (cap_q == '0) begin
      limit = LIM_W'(1);
    end else if (LIM_W'(cap_q) > LIM_W'(DEPTH)) begin
      limit = LIM_W'(DEPTH);
    end
  end

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign cmd    = cmd_e'(cmd_i);
  assign full   = (LIM_W'(count_q) >= limit);
  assign empty  = (count_q == '0);

  // payload sized to the stored width
  assign put_wide  = {32'd0, put_data_i};
  assign head_wide = 64'(c_data[0]);

  // cell control and result
  always_comb begin
    ctl.put    = 1'b0;
    ctl.get    = 1'b0;
    ctl.prio   = put_priority_i;
    ctl.data   = put_wide[MSG_BITS-1:0];
    count_d    = count_q;
    status_d   = ST_OK;
    got_data_d = '0;
    got_prio_d = '0;
    if (accept) begin
      unique case (cmd)
        CMD_PUT: begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            ctl.put = 1'b1;
            count_d = count_q + CNT_W'(1);
          end
        end
        CMD_GET: begin
          if (empty) begin
            status_d = ST_EMPTY;
          end else begin
            ctl.get    = 1'b1;
            count_d    = count_q - CNT_W'(1);
            got_data_d = head_wide[DATA_W-1:0];
            got_prio_d = c_prio[0];
          end
        end
        CMD_CLR: begin
          count_d = '0;
        end
        CMD_NOP: begin
          count_d = count_q;
        end
      endcase
    end
  end

  // count and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q   <= status_d;
    got_data_q <= got_data_d;
    got_prio_q <= got_prio_d;
  end

  assign done_o         = done_q;
  assign status_o       = status_q;
  assign got_data_o     = got_data_q;
  assign got_priority_o = got_prio_q;
  assign held_o         = HELD_W'(count_q);

  // row of slot cells, head at index zero
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic                left_ins;
    logic [MSG_BITS-1:0] left_data;
    logic [PRIO_W-1:0]   left_prio;
    logic [MSG_BITS-1:0] right_data;
    logic [PRIO_W-1:0]   right_prio;

    if (k == 0) begin : g_head
      assign left_ins  = 1'b0;
      assign left_data = c_data[k];
      assign left_prio = c_prio[k];
    end else begin : g_body
      assign left_ins  = ins[k-1];
      assign left_data = c_data[k-1];
      assign left_prio = c_prio[k-1];
    end

    if (k == DEPTH - 1) begin : g_tail
      assign right_data = c_data[k];
      assign right_prio = c_prio[k];
    end else begin : g_next
      assign right_data = c_data[k+1];
      assign right_prio = c_prio[k+1];
    end

    pmq_cell u_cell (
      .clk_i        (clk_i),
      .ctl_i        (ctl),
      .idx_i        (IDX_W'(k)),
      .count_i      (count_q),
      .left_ins_i   (left_ins),
      .left_data_i  (left_data),
      .left_prio_i  (left_prio),
      .right_data_i (right_data),
      .right_prio_i (right_prio),
      .ins_o        (ins[k]),
      .data_o       (c_data[k]),
      .prio_o       (c_prio[k])
    );
  end

endmodule
